// ===== hw/rtl/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  // Fixed field widths
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int BN_W       = 15;
  localparam int CNT_W      = 16;
  localparam int FDB_W      = 15;
  localparam int LIM_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT = 1'b1;

  // Reset values
  localparam logic [FDB_W-1:0] FDB_RESET   = 15'd0;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd32768;
  localparam logic [CNT_W-1:0] COUNT_RESET = 16'd32768;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_FORMAT = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/bba_req_if.sv =====
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BN_W-1:0]   block_number;

  modport source (output valid, kind, block_number, input ready);
  modport sink   (input valid, kind, block_number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bba_rsp_if.sv =====
`default_nettype none

interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BN_W-1:0]     granted_block;
  logic [CNT_W-1:0]    blocks_free;

  modport source (output valid, status, granted_block, blocks_free, input ready);
  modport sink   (input valid, status, granted_block, blocks_free, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
`default_nettype none

// Simple dual-port RAM, registered read.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/block_bitmap_allocator_core.sv =====
// First-fit block allocator over a one-bit-per-block map held in RAM.
//
// Channels: req_i takes words of {kind, block_number}; rsp_o returns one word
// of {status, granted_block, blocks_free} per request. Both are valid/ready.
// The config port (cfg_we_i, cfg_index_i, cfg_data_i) writes first_data_block
// (index 0) and block_limit (index 1); write only when idle.
//
// Work from accept to rsp valid, set by the map RAM's single read port:
//   unknown kind / empty-range allocate : straight to DONE; free : one word read
//   allocate : map words read in order, one word per cycle, worst case
//              every word from first_data_block to the limit (1024 at defaults)
//   format   : the whole map depth in words, one word cleared per cycle
// One request in flight; the next is taken the cycle after the result enters
// the output register. A stalled rsp_o holds the block until that register frees.
//
// Reset: registers with a reset take their reset values, the count reads
// 32768 and the map is swept to zero, one word per cycle over the map depth
// (1024 words at defaults); req_i.ready stays low during the sweep. Config
// writes are taken. Map words are MAP_WORD_BITS rounded down to a power of two;
// block to word/bit is a shift and a mask.

`default_nettype none

module block_bitmap_allocator_core import bba_pkg::*; #(
  parameter int MAX_BLOCKS    = 32768,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bba_req_if.sink               req_i,
  bba_rsp_if.source             rsp_o
);

  localparam int L     = $clog2(MAP_WORD_BITS + 1) - 1;
  localparam int WB    = 1 << L;
  localparam int WORDS = (MAX_BLOCKS + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(MAX_BLOCKS);
  localparam int CW    = (BW + 1 > LIM_W) ? BW + 1 : LIM_W;

  localparam logic [CW-1:0] MAX_C     = CW'(MAX_BLOCKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  // ---------------------------------------------------------------- config
  logic [FDB_W-1:0] fdb_q;
  logic [LIM_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q <= FDB_RESET;
      lim_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIRST_DATA:  fdb_q <= cfg_data_i[FDB_W-1:0];
        REG_BLOCK_LIMIT: lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Data range [fdb, eff_lim), limit clamped to the map size
  logic [CW-1:0] lim_ext, eff_lim, fdb_ext, last_blk, bn_ext;
  logic          range_ok, bn_in_range;
  logic [AW-1:0] first_w, last_w, bn_w;
  logic [L-1:0]  first_b, last_b;

  assign lim_ext     = CW'(lim_q);
  assign eff_lim     = (lim_ext > MAX_C) ? MAX_C : lim_ext;
  assign fdb_ext     = CW'(fdb_q);
  assign range_ok    = fdb_ext < eff_lim;
  assign last_blk    = eff_lim - CW'(1);
  assign first_w     = AW'(fdb_ext >> L);
  assign first_b     = fdb_ext[L-1:0];
  assign last_w      = AW'(last_blk >> L);
  assign last_b      = last_blk[L-1:0];
  assign bn_ext      = CW'(req_i.block_number);
  assign bn_in_range = (bn_ext >= fdb_ext) && (bn_ext < eff_lim);
  assign bn_w        = AW'(bn_ext >> L);

  // ---------------------------------------------------------------- map RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0] ram_wdata, ram_rdata;

  bba_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- state
  state_e           state_q, state_d;
  logic [AW-1:0]    word_q, word_d;
  logic [L-1:0]     bit_q, bit_d;
  logic             fmt_q, fmt_d;
  status_e          status_q, status_d;
  logic [BN_W-1:0]  grant_q, grant_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             rsp_valid_q, rsp_valid_d;
  status_e          rsp_status_q;
  logic [BN_W-1:0]  rsp_grant_q;
  logic [CNT_W-1:0] rsp_count_q;
  logic             out_load;

  logic             accept;
  logic             out_free;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // Free bits of the word under scan; bits outside the data range look used
  logic [WB-1:0] free_vec, low_hot;
  logic [L-1:0]  hit_idx;
  logic [CW-1:0] hit_blk;

  always_comb begin
    for (int j = 0; j < WB; j++) begin
      free_vec[j] = !ram_rdata[j]
                    && !((word_q == first_w) && (L'(j) < first_b))
                    && !((word_q == last_w) && (L'(j) > last_b));
    end
  end

  assign low_hot = free_vec & (~free_vec + WB'(1));

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < WB; j++) begin
      if (low_hot[j]) begin
        hit_idx = hit_idx | L'(j);
      end
    end
  end

  assign hit_blk = (CW'(word_q) << L) | CW'(hit_idx);

  // Read-modify-write: every write lands before the next request's read
  // is issued (DONE and IDLE lie between), so no forwarding is needed.
  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    bit_d     = bit_q;
    fmt_d     = fmt_q;
    status_d  = status_q;
    grant_d   = grant_q;
    count_d   = count_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = word_q;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (word_q == LAST_ADDR) begin
          if (fmt_q) begin
            status_d = ST_OK;
            grant_d  = '0;
            count_d  = range_ok ? CNT_W'(eff_lim - fdb_ext) : '0;
            state_d  = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          word_d = word_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          grant_d = '0;
          case (req_i.kind)
            KIND_ALLOC: begin
              if (range_ok) begin
                ram_re    = 1'b1;
                ram_raddr = first_w;
                word_d    = first_w;
                state_d   = S_SCAN;
              end else begin
                status_d = ST_NO_FREE;
                state_d  = S_DONE;
              end
            end
            KIND_FREE: begin
              if (bn_in_range) begin
                ram_re    = 1'b1;
                ram_raddr = bn_w;
                word_d    = bn_w;
                bit_d     = bn_ext[L-1:0];
                state_d   = S_FREE;
              end else begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            KIND_FORMAT: begin
              word_d  = '0;
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              status_d = ST_RANGE;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (|free_vec) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | low_hot;
          status_d  = ST_OK;
          grant_d   = hit_blk[BN_W-1:0];
          count_d   = (count_q == '0) ? '0 : count_q - CNT_W'(1);
          state_d   = S_DONE;
        end else if (word_q == last_w) begin
          status_d = ST_NO_FREE;
          state_d  = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = word_q + AW'(1);
          word_d    = word_q + AW'(1);
        end
      end

      S_FREE: begin
        if (ram_rdata[bit_q]) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WB'(1) << bit_q);
          status_d  = ST_OK;
          count_d   = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + CNT_W'(1);
        end else begin
          status_d = ST_NOT_ALLOC;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          fmt_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_valid_d = out_load || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      fmt_q       <= 1'b0;
      count_q     <= COUNT_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      fmt_q       <= fmt_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q    <= bit_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    if (out_load) begin
      rsp_status_q <= status_q;
      rsp_grant_q  <= grant_q;
      rsp_count_q  <= count_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.granted_block = rsp_grant_q;
  assign rsp_o.blocks_free   = rsp_count_q;

  // ---------------------------------------------------------------- checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("request accepted but FSM stayed idle");

  a_clear_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!req_i.ready && !ram_re))
    else $error("request or map read during clearing sweep");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("map read and write in the same cycle");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.granted_block == '0))
    else $error("non-zero grant on a failed request");

  a_count_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && (|free_vec) && (count_q == '0)) |=> (count_q == '0))
    else $error("free count wrapped below zero");

endmodule

`default_nettype wire
